[rtl/icc_seg_pkg.sv]
// Shared types, codes and header byte table for the ICC APP2 segmenter.
package icc_seg_pkg;

  localparam int SEG_W = 16;
  localparam int REM_W = 24;
  localparam int IDX_W = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // Position of the data byte behind an 18-byte header
  localparam logic [IDX_W-1:0] DATA_IDX = IDX_W'(18);

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_APP2 = 8'hE2;
  localparam logic [SEG_W-1:0] LEN_EXTRA = SEG_W'(16);

  localparam logic [7:0] ICC_TAG [12] = '{
    8'h49, 8'h43, 8'h43, 8'h5F, 8'h50, 8'h52,
    8'h4F, 8'h46, 8'h49, 8'h4C, 8'h45, 8'h00
  };

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_HDR = 2'd1;
  localparam kind_t KIND_OVR = 2'd2;

  typedef struct packed {
    kind_t kind;
    logic [7:0] data;
    logic done;
    logic [SEG_W-1:0] seglen;
    logic [7:0] seq;
    logic [7:0] count;
  } seg_cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input seg_cmd_t c);
    logic [IDX_W-1:0] t;
    logic [7:0] b;
    t = idx - IDX_W'(4);
    unique case (idx) inside
      IDX_W'(0): b = MARKER_PREFIX;
      IDX_W'(1): b = MARKER_APP2;
      IDX_W'(2): b = c.seglen[15:8];
      IDX_W'(3): b = c.seglen[7:0];
      [IDX_W'(4):IDX_W'(15)]: b = ICC_TAG[t[3:0]];
      IDX_W'(16): b = c.seq;
      IDX_W'(17): b = c.count;
      default: b = c.data;
    endcase
    return b;
  endfunction

endpackage

[rtl/icc_profile_app2_segmenter.sv]
// ICC profile to JPEG APP2 marker framer, top level.
// Throughput: one beat out per cycle while out_stall is low; a byte that opens a segment yields 19 beats
//   (18 header beats, then the data beat), every other byte yields one beat.
// Path from input accept to the first output beat: the queue, then the output register.
// A profile_length write is accepted at once (cfg_ready stays high) and loads the
//   marker count at that edge; in_stall is held while cfg_valid is high.
// Reset (rst_n low, synchronous): profile_length 1, marker count 1, queue and output empty.
module icc_profile_app2_segmenter #(
  parameter int MAX_SEGMENT_DATA = 65519
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [7:0] in_profile_byte,
  output logic in_stall,
  input  logic cfg_valid,
  input  logic [23:0] cfg_profile_length,
  output logic cfg_ready,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_byte,
  output logic out_run_last,
  output logic out_profile_done,
  output logic out_overrun
);
  import icc_seg_pkg::*;

  seg_cmd_t wr_cmd, rd_cmd;
  logic push, pop, empty, full;

  // Front: classify each beat as header-opening, plain data or overrun
  icc_seg_front #(.MAX_SEGMENT_DATA(MAX_SEGMENT_DATA)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_profile_byte(in_profile_byte), .in_stall(in_stall),
    .cfg_valid(cfg_valid), .cfg_profile_length(cfg_profile_length),
    .cfg_ready(cfg_ready),
    .full(full), .push(push), .cmd(wr_cmd)
  );

  // Queue decouples input acceptance from header expansion
  icc_seg_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wr_cmd(wr_cmd), .pop(pop), .rd_cmd(rd_cmd),
    .empty(empty), .full(full)
  );

  // Back: emit header beats, then the data beat, through the output register
  icc_seg_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd(rd_cmd), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_run_last(out_run_last), .out_profile_done(out_profile_done),
    .out_overrun(out_overrun)
  );

endmodule

[rtl/icc_seg_div.sv]
// Marker count: ceil(length / segment size) by reciprocal multiply, registered on a write.
module icc_seg_div #(
  parameter int MAX_SEGMENT_DATA = 65519
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [icc_seg_pkg::REM_W-1:0] length,
  output logic [7:0] count
);
  import icc_seg_pkg::*;

  localparam int DQ_W = REM_W + 1;
  localparam int SHIFT = DQ_W + $clog2(MAX_SEGMENT_DATA);
  localparam int RCP_W = DQ_W + 2;
  localparam int PROD_W = DQ_W + RCP_W;
  localparam logic [DQ_W-1:0] ROUND_UP = DQ_W'(MAX_SEGMENT_DATA - 1);
  // ceil(2^SHIFT / segment size): exact floor quotient for any DQ_W-bit numerator
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(MAX_SEGMENT_DATA - 1)) / 64'(MAX_SEGMENT_DATA);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_FULL);

  logic [DQ_W-1:0] num;
  logic [PROD_W-1:0] prod;
  logic [7:0] count_r;

  always_comb begin
    num = {1'b0, length} + ROUND_UP;
    prod = PROD_W'(num) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd1;
    end else if (start) begin
      count_r <= prod[SHIFT+7:SHIFT];
    end
  end

  assign count = count_r;

endmodule

[rtl/icc_seg_front.sv]
// Front end: accept profile bytes, track segments, queue one command per beat.
module icc_seg_front #(
  parameter int MAX_SEGMENT_DATA = 65519
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [7:0] in_profile_byte,
  output logic in_stall,
  input  logic cfg_valid,
  input  logic [23:0] cfg_profile_length,
  output logic cfg_ready,
  input  logic full,
  output logic push,
  output icc_seg_pkg::seg_cmd_t cmd
);
  import icc_seg_pkg::*;

  localparam logic [REM_W-1:0] MAX_SEG = REM_W'(MAX_SEGMENT_DATA);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [SEG_W-1:0] seg_left_r, seg_left_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [REM_W-1:0] seg;
  logic cfg_we, accept;
  logic [7:0] count;

  icc_seg_div #(.MAX_SEGMENT_DATA(MAX_SEGMENT_DATA)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cfg_we), .length(cfg_profile_length),
    .count(count)
  );

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid & cfg_ready;
  assign in_stall = full | cfg_valid;
  assign accept = in_valid & ~in_stall;
  assign push = accept;

  always_comb begin
    seg = (rem_r > MAX_SEG) ? MAX_SEG : rem_r;
    rem_nxt = rem_r;
    seg_left_nxt = seg_left_r;
    seq_nxt = seq_r;
    cmd.kind = KIND_DATA;
    cmd.data = in_profile_byte;
    cmd.done = (rem_r == REM_W'(1));
    cmd.seglen = seg[SEG_W-1:0] + LEN_EXTRA;
    cmd.seq = seq_r;
    cmd.count = count;
    if (rem_r == '0) begin
      // Profile complete: drop the byte, flag it
      cmd.kind = KIND_OVR;
      cmd.data = 8'h00;
      cmd.done = 1'b0;
    end else begin
      rem_nxt = rem_r - REM_W'(1);
      if (seg_left_r == '0) begin
        cmd.kind = KIND_HDR;
        seg_left_nxt = seg[SEG_W-1:0] - SEG_W'(1);
        seq_nxt = seq_r + 8'd1;
      end else begin
        seg_left_nxt = seg_left_r - SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= REM_W'(1);
      seg_left_r <= '0;
      seq_r <= 8'd1;
    end else if (cfg_we) begin
      rem_r <= cfg_profile_length;
      seg_left_r <= '0;
      seq_r <= 8'd1;
    end else if (accept) begin
      rem_r <= rem_nxt;
      seg_left_r <= seg_left_nxt;
      seq_r <= seq_nxt;
    end
  end

endmodule

[rtl/icc_seg_fifo.sv]
// Small command queue between front and back end.
module icc_seg_fifo (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  icc_seg_pkg::seg_cmd_t wr_cmd,
  input  logic pop,
  output icc_seg_pkg::seg_cmd_t rd_cmd,
  output logic empty,
  output logic full
);
  import icc_seg_pkg::*;

  seg_cmd_t mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0] fill_r;

  assign empty = (fill_r == '0);
  assign full = (fill_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

[rtl/icc_seg_back.sv]
// Back end: expand queued commands into marker bytes through an output register.
module icc_seg_back (
  input  logic clk,
  input  logic rst_n,
  input  icc_seg_pkg::seg_cmd_t cmd,
  input  logic empty,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_byte,
  output logic out_run_last,
  output logic out_profile_done,
  output logic out_overrun
);
  import icc_seg_pkg::*;

  logic [IDX_W-1:0] idx_r, idx;
  logic out_valid_r;
  logic [7:0] byte_r;
  logic last_r, done_r, over_r;
  logic load, is_last;

  assign idx = (cmd.kind == KIND_HDR) ? idx_r : DATA_IDX;
  assign is_last = (idx == DATA_IDX);
  assign load = ~empty & (~out_valid_r | ~out_stall);
  assign pop = load & is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r <= is_last ? '0 : idx_r + IDX_W'(1);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= hdr_byte(idx, cmd);
      last_r <= is_last;
      done_r <= is_last & cmd.done;
      over_r <= is_last & (cmd.kind == KIND_OVR);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = byte_r;
  assign out_run_last = last_r;
  assign out_profile_done = done_r;
  assign out_overrun = over_r;

endmodule

[bench/icc_app2_stream_checker.sv]
`timescale 1ns / 100ps
// Stream checker for the APP2 segmenter: models the framing and compares every output beat.
module icc_app2_stream_checker #(
  parameter int MAX_SEG = 65519
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [7:0] in_profile_byte,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [23:0] cfg_profile_length,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [7:0] out_byte,
  input  logic out_run_last,
  input  logic out_profile_done,
  input  logic out_overrun,
  output int fail_count,
  output int pending
);

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_APP2 = 8'hE2;
  localparam logic [7:0] ICC_ID [12] = '{
    8'h49, 8'h43, 8'h43, 8'h5F, 8'h50, 8'h52,
    8'h4F, 8'h46, 8'h49, 8'h4C, 8'h45, 8'h00
  };

  typedef struct packed {
    logic [7:0] data;
    logic last;
    logic done;
    logic over;
  } marker_beat_t;

  marker_beat_t marker_beats[$];

  logic [23:0] prof_len;
  logic [23:0] bytes_left;
  logic [15:0] seg_left;
  logic [7:0] seq_no;
  int errors = 0;

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("checker: %s expected %02h got %02h at %0t", what, want, got, $time);
    errors++;
  endtask

  function automatic void push_beat(input logic [7:0] d, input logic last,
                                    input logic done, input logic over);
    marker_beat_t b;
    b.data = d;
    b.last = last;
    b.done = done;
    b.over = over;
    marker_beats.push_back(b);
  endfunction

  // Work out the beats one accepted profile byte produces.
  task automatic frame_byte(input logic [7:0] d);
    logic [23:0] seg;
    logic [31:0] markers;
    logic [15:0] hdr_len;
    if (bytes_left == 24'd0) begin
      push_beat(8'h00, 1'b1, 1'b0, 1'b1);
      return;
    end
    if (seg_left == 16'd0) begin
      seg = (bytes_left > 24'(MAX_SEG)) ? 24'(MAX_SEG) : bytes_left;
      markers = (32'(prof_len) + 32'(MAX_SEG) - 32'd1) / 32'(MAX_SEG);
      hdr_len = 16'(seg + 24'd16);
      push_beat(MARK_PREFIX, 1'b0, 1'b0, 1'b0);
      push_beat(MARK_APP2, 1'b0, 1'b0, 1'b0);
      push_beat(hdr_len[15:8], 1'b0, 1'b0, 1'b0);
      push_beat(hdr_len[7:0], 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < 12; i++)
        push_beat(ICC_ID[i], 1'b0, 1'b0, 1'b0);
      push_beat(seq_no, 1'b0, 1'b0, 1'b0);
      push_beat(markers[7:0], 1'b0, 1'b0, 1'b0);
      seg_left = seg[15:0];
      seq_no = seq_no + 8'd1;
    end
    bytes_left = bytes_left - 24'd1;
    seg_left = seg_left - 16'd1;
    push_beat(d, 1'b1, bytes_left == 24'd0, 1'b0);
  endtask

  always @(posedge clk) begin
    marker_beat_t want;
    if (!rst_n) begin
      prof_len = 24'd1;
      bytes_left = 24'd1;
      seg_left = 16'd0;
      seq_no = 8'd1;
      marker_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (marker_beats.size() == 0) begin
          report_mismatch("unexpected beat", 8'h00, out_byte);
        end else begin
          want = marker_beats.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", want.data, out_byte);
          if (out_run_last !== want.last)
            report_mismatch("run_last", 8'(want.last), 8'(out_run_last));
          if (out_profile_done !== want.done)
            report_mismatch("profile_done", 8'(want.done), 8'(out_profile_done));
          if (out_overrun !== want.over)
            report_mismatch("overrun", 8'(want.over), 8'(out_overrun));
        end
      end
      // A length write restarts the framing from the first segment.
      if (cfg_valid && cfg_ready) begin
        prof_len = cfg_profile_length;
        bytes_left = cfg_profile_length;
        seg_left = 16'd0;
        seq_no = 8'd1;
      end
      if (in_valid && !in_stall)
        frame_byte(in_profile_byte);
    end
    pending <= marker_beats.size();
    fail_count <= errors;
  end

endmodule

[bench/icc_profile_app2_segmenter_tb.sv]
`timescale 1ns / 100ps
// Top-level bench for the APP2 segmenter: clock, reset, stimulus, idling and verdict.
module icc_profile_app2_segmenter_tb;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_profile_byte = 8'h00;
  logic in_stall;
  logic cfg_valid = 1'b0;
  logic [23:0] cfg_profile_length = 24'd0;
  logic cfg_ready;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_run_last;
  logic out_profile_done;
  logic out_overrun;

  int fail_count;
  int pending;

  // Idle rates in percent: sender gaps and receiver stalls.
  int gap_pct = 0;
  int stall_pct = 0;
  int rand_items = 0;

  icc_profile_app2_segmenter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_profile_byte(in_profile_byte),
    .in_stall(in_stall),
    .cfg_valid(cfg_valid),
    .cfg_profile_length(cfg_profile_length),
    .cfg_ready(cfg_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_run_last(out_run_last),
    .out_profile_done(out_profile_done),
    .out_overrun(out_overrun)
  );

  icc_app2_stream_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_profile_byte(in_profile_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_profile_length(cfg_profile_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_run_last(out_run_last),
    .out_profile_done(out_profile_done),
    .out_overrun(out_overrun),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver side: stall at the current phase's rate, never during reset.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Drive one profile byte; insert random idle cycles first, then hold until accepted.
  // Valid stays high on return so back-to-back beats need no drop.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_profile_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the profile length once the block is idle; hold valid until ready.
  task automatic write_length(input logic [23:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_profile_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Configure a length and push a number of random bytes into it.
  task automatic run_profile(input logic [23:0] len, input int nbytes);
    write_length(len);
    repeat (nbytes) send_byte(8'($urandom_range(255)));
    rand_items += nbytes;
  endtask

  initial begin : stimulus
    logic [23:0] len;
    int nbytes;
    int pick;
    int phase_items;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset length of one, then an overrun on the next byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Zero length: every byte is an overrun.
    write_length(24'd0);
    send_byte(8'h80);
    send_byte(8'h01);
    write_length(24'd1);
    send_byte(8'hFF);
    // Short profile finished, then one byte past the end.
    write_length(24'd3);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h3C);
    // Top of the range: full-size first segment, 255 markers.
    write_length(24'd16707345);
    send_byte(8'h12);
    send_byte(8'h34);
    // Above the range: marker count wraps.
    write_length(24'hFFFFFF);
    send_byte(8'hFE);
    send_byte(8'h7F);
    // Exactly one full segment.
    write_length(24'd65519);
    send_byte(8'h55);

    // Random phases: mostly complete profiles, some abandoned, some huge or empty.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 68;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 68;
        end
        default: begin
          gap_pct = 13;
          stall_pct <= 13;
        end
      endcase
      phase_items = rand_items;
      while (rand_items - phase_items < 110) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          len = 24'($urandom_range(24, 1));
          nbytes = int'(len) + $urandom_range(2);
        end else if (pick < 85) begin
          len = 24'($urandom_range(30, 2));
          nbytes = $urandom_range(int'(len) - 1, 1);
        end else if (pick < 95) begin
          len = 24'($urandom());
          nbytes = $urandom_range(6, 1);
        end else begin
          len = 24'd0;
          nbytes = $urandom_range(3, 1);
        end
        run_profile(len, nbytes);
      end
    end

    // Wait out every expected beat, then give the verdict.
    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
